// File: hdl/svcq_pkg.sv
package svcq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_SERVE = 2'd1,
    OP_UNDO  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_QUEUE_EMPTY = 3'd1,
    ST_HIST_EMPTY  = 3'd2,
    ST_QUEUE_FULL  = 3'd3,
    ST_HIST_FULL   = 3'd4
  } st_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ENQ   = 2'd1,
    ACT_SERVE = 2'd2,
    ACT_UNDO  = 2'd3
  } act_t;

  localparam int CID_W  = 16;
  localparam int KIND_W = 2;
  localparam int TS_W   = 32;
  localparam int CNT_W  = 5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CID_W-1:0]  cid;
  } wentry_t;

  typedef struct packed {
    logic [TS_W-1:0] ts;
    wentry_t         e;
  } hentry_t;

  typedef struct packed {
    st_t               status;
    logic [CID_W-1:0]  cid;
    logic [KIND_W-1:0] kind;
    logic [TS_W-1:0]   ts;
    logic [CNT_W-1:0]  qcnt;
    logic [CNT_W-1:0]  hcnt;
  } result_t;

endpackage

// File: hdl/service_queue_with_undo_history.sv
// Service queue with undo history. Each request (tuser opcode: enqueue, serve,
// undo) returns exactly one result carrying the status, the entry served or
// undone, and both occupancies after the operation. One request is taken per
// cycle while results are taken; a result passes the stage-one registers and
// then the output buffer. Pointer and count updates are decided at acceptance,
// entry memories are read then and written in the next cycle with a one-deep
// bypass, and a two-entry output buffer keeps the input side running while a
// result waits to be taken. Entry memories need no clearing after reset.
module service_queue_with_undo_history
  import svcq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // customer_id, service_kind, timestamp, pad
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // customer_id, service_kind, timestamp,
                                  // queue_count, history_count, pad
  output logic [2:0]  out_tuser   // status
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  op_t               in_op;
  logic [CID_W-1:0]  in_cid;
  logic [KIND_W-1:0] in_kind;
  logic [TS_W-1:0]   in_ts;
  logic              in_acc;

  assign in_op   = op_t'(in_tuser);
  assign in_cid  = in_tdata[15:0];
  assign in_kind = in_tdata[17:16];
  assign in_ts   = in_tdata[49:18];

  logic [QAW-1:0] head_r, head_nxt, tail_r, tail_nxt, head_inc, tail_inc;
  logic [QCW-1:0] qcnt_r, qcnt_nxt;
  logic [HCW-1:0] htop_r, htop_nxt;
  logic [HAW-1:0] hrd_addr;
  logic           q_full, q_empty, h_full, h_empty;
  act_t           dec_act;
  st_t            dec_st;

  logic              s1_v_r;
  act_t              s1_act_r;
  st_t               s1_st_r;
  logic [QAW-1:0]    s1_qaddr_r;
  logic [HAW-1:0]    s1_haddr_r;
  logic [CID_W-1:0]  s1_cid_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic [TS_W-1:0]   s1_ts_r;
  logic [QCW-1:0]    s1_qcnt_r;
  logic [HCW-1:0]    s1_hcnt_r;
  wentry_t           wrd_r;
  hentry_t           hrd_r;

  wentry_t wmem [QUEUE_DEPTH];
  hentry_t hmem [HISTORY_DEPTH];

  logic    w_we, h_we;
  wentry_t w_wdata;
  hentry_t h_wdata;

  result_t        s1_res;
  result_t        ob_data;
  logic [1:0]     ob_level;
  logic           out_pop;
  logic [QCW+4:0] qc_wide;
  logic [HCW+4:0] hc_wide;

  assign q_full   = (qcnt_r == QCW'(QUEUE_DEPTH));
  assign q_empty  = (qcnt_r == '0);
  assign h_full   = (htop_r == HCW'(HISTORY_DEPTH));
  assign h_empty  = (htop_r == '0);
  assign head_inc = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign hrd_addr = HAW'(htop_r - 1'b1);

  always_comb begin
    dec_act = ACT_NONE;
    dec_st  = ST_OK;
    case (in_op)
      OP_ENQ: begin
        if (q_full) begin
          dec_st = ST_QUEUE_FULL;
        end else begin
          dec_act = ACT_ENQ;
        end
      end
      OP_SERVE: begin
        if (q_empty) begin
          dec_st = ST_QUEUE_EMPTY;
        end else if (h_full) begin
          dec_st = ST_HIST_FULL;
        end else begin
          dec_act = ACT_SERVE;
        end
      end
      OP_UNDO: begin
        if (h_empty) begin
          dec_st = ST_HIST_EMPTY;
        end else if (q_full) begin
          dec_st = ST_QUEUE_FULL;
        end else begin
          dec_act = ACT_UNDO;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    qcnt_nxt = qcnt_r;
    htop_nxt = htop_r;
    if (in_acc) begin
      case (dec_act)
        ACT_ENQ: begin
          tail_nxt = tail_inc;
          qcnt_nxt = qcnt_r + 1'b1;
        end
        ACT_SERVE: begin
          head_nxt = head_inc;
          qcnt_nxt = qcnt_r - 1'b1;
          htop_nxt = htop_r + 1'b1;
        end
        ACT_UNDO: begin
          tail_nxt = tail_inc;
          qcnt_nxt = qcnt_r + 1'b1;
          htop_nxt = htop_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      qcnt_r <= '0;
      htop_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      qcnt_r <= qcnt_nxt;
      htop_r <= htop_nxt;
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r   <= dec_act;
      s1_st_r    <= dec_st;
      s1_qaddr_r <= tail_r;
      s1_haddr_r <= htop_r[HAW-1:0];
      s1_cid_r   <= in_cid;
      s1_kind_r  <= in_kind;
      s1_ts_r    <= in_ts;
      s1_qcnt_r  <= qcnt_nxt;
      s1_hcnt_r  <= htop_nxt;
    end
  end

  // writes land in the cycle after the request; bypass covers the next read
  assign w_we    = s1_v_r && (s1_act_r == ACT_ENQ || s1_act_r == ACT_UNDO);
  assign w_wdata = (s1_act_r == ACT_ENQ) ? wentry_t'{kind: s1_kind_r, cid: s1_cid_r}
                                         : hrd_r.e;
  assign h_we    = s1_v_r && (s1_act_r == ACT_SERVE);
  assign h_wdata = hentry_t'{ts: s1_ts_r, e: wrd_r};

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[s1_qaddr_r] <= w_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (w_we && (s1_qaddr_r == head_r)) begin
        wrd_r <= w_wdata;
      end else begin
        wrd_r <= wmem[head_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[s1_haddr_r] <= h_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (h_we && (s1_haddr_r == hrd_addr)) begin
        hrd_r <= h_wdata;
      end else begin
        hrd_r <= hmem[hrd_addr];
      end
    end
  end

  assign qc_wide = {5'd0, s1_qcnt_r};
  assign hc_wide = {5'd0, s1_hcnt_r};

  always_comb begin
    s1_res.status = s1_st_r;
    s1_res.cid    = '0;
    s1_res.kind   = '0;
    s1_res.ts     = '0;
    s1_res.qcnt   = qc_wide[4:0];
    s1_res.hcnt   = hc_wide[4:0];
    case (s1_act_r)
      ACT_SERVE: begin
        s1_res.cid  = wrd_r.cid;
        s1_res.kind = wrd_r.kind;
        s1_res.ts   = s1_ts_r;
      end
      ACT_UNDO: begin
        s1_res.cid  = hrd_r.e.cid;
        s1_res.kind = hrd_r.e.kind;
        s1_res.ts   = hrd_r.ts;
      end
      default: begin
      end
    endcase
  end

  svcq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data (s1_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (ob_data),
    .level     (ob_level)
  );

  assign out_pop   = out_tvalid & out_tready;
  // room for the request in flight plus this one
  assign in_tready = ({1'b0, ob_level} + {2'b00, s1_v_r}) <= ({2'b00, out_pop} + 3'd1);
  assign in_acc    = in_tvalid & in_tready;

  assign out_tuser = ob_data.status;
  assign out_tdata = {4'd0, ob_data.hcnt, ob_data.qcnt, ob_data.ts, ob_data.kind,
                      ob_data.cid};

`ifndef ASSERT_OFF
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_htop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    htop_r <= HCW'(HISTORY_DEPTH))
    else $error("history occupancy above depth");

  a_serve_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec_act == ACT_SERVE) |=>
      (qcnt_r == $past(qcnt_r) - 1'b1) && (htop_r == $past(htop_r) + 1'b1))
    else $error("serve did not move one entry into history");

  a_buf_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (ob_level != 2'd2) || out_pop)
    else $error("result pushed into full output buffer");
`endif

endmodule

// File: hdl/svcq_out_buf.sv
module svcq_out_buf
  import svcq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    push_data,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data,
  output logic [1:0] level
);

  logic [1:0] lvl_r, lvl_nxt;
  result_t    e0_r, e0_nxt, e1_r, e1_nxt;
  logic       pop;

  assign out_valid = (lvl_r != 2'd0);
  assign out_data  = e0_r;
  assign level     = lvl_r;
  assign pop       = out_valid & out_ready;

  always_comb begin
    lvl_nxt = lvl_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    case ({push, pop})
      2'b10: begin
        if (lvl_r == 2'd0) begin
          e0_nxt = push_data;
        end else begin
          e1_nxt = push_data;
        end
        lvl_nxt = lvl_r + 2'd1;
      end
      2'b01: begin
        e0_nxt  = e1_r;
        lvl_nxt = lvl_r - 2'd1;
      end
      2'b11: begin
        if (lvl_r == 2'd1) begin
          e0_nxt = push_data;
        end else begin
          e0_nxt = e1_r;
          e1_nxt = push_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= 2'd0;
    end else begin
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

// File: dv/tb_service_queue_with_undo_history.sv
module tb_service_queue_with_undo_history
  import svcq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam int HDEPTH = 16;
  localparam int ITEMS_PER_PHASE = 630;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // customer_id, service_kind, timestamp, pad
  logic [1:0]  in_tuser = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // customer_id, service_kind, timestamp,
                                // queue_count, history_count, pad
  logic [2:0]  out_tuser;       // status

  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;

  service_queue_with_undo_history uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  class service_scoreboard;
    logic [15:0] wait_cid [QDEPTH];
    logic [1:0]  wait_kind [QDEPTH];
    int          wait_rd = 0;
    int          wait_wr = 0;
    int          wait_cnt = 0;
    logic [15:0] hist_cid [HDEPTH];
    logic [1:0]  hist_kind [HDEPTH];
    logic [31:0] hist_ts [HDEPTH];
    int          hist_cnt = 0;
    result_t     expected_q[$];
    int          errors = 0;

    function void fifo_push(logic [15:0] cid, logic [1:0] kind);
      wait_cid[wait_wr] = cid;
      wait_kind[wait_wr] = kind;
      wait_wr = (wait_wr + 1) % QDEPTH;
      wait_cnt++;
    endfunction

    // request accepted: advance the model and queue its result
    function void note(op_t op, logic [15:0] cid, logic [1:0] kind, logic [31:0] ts);
      result_t r;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_ENQ: begin
          if (wait_cnt >= QDEPTH) r.status = ST_QUEUE_FULL;
          else fifo_push(cid, kind);
        end
        OP_SERVE: begin
          if (wait_cnt == 0) r.status = ST_QUEUE_EMPTY;
          else if (hist_cnt >= HDEPTH) r.status = ST_HIST_FULL;
          else begin
            r.cid = wait_cid[wait_rd];
            r.kind = wait_kind[wait_rd];
            r.ts = ts;
            wait_rd = (wait_rd + 1) % QDEPTH;
            wait_cnt--;
            hist_cid[hist_cnt] = r.cid;
            hist_kind[hist_cnt] = r.kind;
            hist_ts[hist_cnt] = ts;
            hist_cnt++;
          end
        end
        OP_UNDO: begin
          if (hist_cnt == 0) r.status = ST_HIST_EMPTY;
          else if (wait_cnt >= QDEPTH) r.status = ST_QUEUE_FULL;
          else begin
            hist_cnt--;
            r.cid = hist_cid[hist_cnt];
            r.kind = hist_kind[hist_cnt];
            r.ts = hist_ts[hist_cnt];
            fifo_push(r.cid, r.kind);
          end
        end
        default: ;
      endcase
      r.qcnt = wait_cnt[4:0];
      r.hcnt = hist_cnt[4:0];
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("customer_id", want.cid, got.cid);
      cmp_field("service_kind", want.kind, got.kind);
      cmp_field("timestamp", want.ts, got.ts);
      cmp_field("queue_count", want.qcnt, got.qcnt);
      cmp_field("history_count", want.hcnt, got.hcnt);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  service_scoreboard sb = new();

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = st_t'(out_tuser);
      got.cid = out_tdata[15:0];
      got.kind = out_tdata[17:16];
      got.ts = out_tdata[49:18];
      got.qcnt = out_tdata[54:50];
      got.hcnt = out_tdata[59:55];
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("service_queue_with_undo_history test failed");
    $finish;
  end

  task automatic send_req(op_t op, logic [15:0] cid, logic [1:0] kind, logic [31:0] ts);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, ts, kind, cid};
    do @(posedge clk); while (!in_tready);
    sb.note(op, cid, kind, ts);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // segments of biased traffic so both stores reach full and empty
  task automatic send_random(int n);
    int mode;
    int pick;
    op_t op;
    mode = 3;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) mode = $urandom_range(3);
      pick = $urandom_range(99);
      case (mode)
        0: op = pick < 70 ? OP_ENQ : pick < 90 ? OP_SERVE : pick < 98 ? OP_UNDO : OP_NOP;
        1: op = pick < 15 ? OP_ENQ : pick < 90 ? OP_SERVE : pick < 98 ? OP_UNDO : OP_NOP;
        2: op = pick < 10 ? OP_ENQ : pick < 35 ? OP_SERVE : pick < 98 ? OP_UNDO : OP_NOP;
        default: op = pick < 33 ? OP_ENQ : pick < 66 ? OP_SERVE : pick < 98 ? OP_UNDO : OP_NOP;
      endcase
      send_req(op, 16'($urandom), 2'($urandom_range(3)), $urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 27;
    recv_idle = 48;
    send_req(OP_SERVE, 16'h5a5a, 2'd1, 32'h1);
    send_req(OP_UNDO, 16'h0, 2'd0, 32'h0);
    send_req(OP_NOP, 16'hffff, 2'd3, 32'hffffffff);
    send_req(OP_ENQ, 16'hffff, 2'd3, 32'hffffffff);
    send_req(OP_ENQ, 16'h0000, 2'd0, 32'h0);
    send_req(OP_ENQ, 16'h1234, 2'd1, 32'h0);
    send_req(OP_ENQ, 16'habcd, 2'd2, 32'h0);
    send_req(OP_SERVE, 16'h0, 2'd0, 32'hffffffff);
    send_req(OP_SERVE, 16'hffff, 2'd3, 32'h0);
    send_req(OP_UNDO, 16'h0, 2'd0, 32'h0);
    send_req(OP_UNDO, 16'h0, 2'd0, 32'h0);
    send_req(OP_UNDO, 16'h0, 2'd0, 32'h0);
    send_req(OP_SERVE, 16'h0, 2'd0, 32'h89abcdef);
    send_req(OP_SERVE, 16'h0, 2'd0, 32'h80000000);
    send_req(OP_SERVE, 16'h0, 2'd0, 32'h00000001);
    send_req(OP_SERVE, 16'h0, 2'd0, 32'h7fffffff);
    send_req(OP_SERVE, 16'h0, 2'd0, 32'h0);
    send_req(OP_UNDO, 16'h0, 2'd0, 32'h0);
    send_req(OP_NOP, 16'h0, 2'd0, 32'h0);
    send_random(ITEMS_PER_PHASE);
    drain_results();

    send_idle = 48;
    recv_idle = 27;
    send_random(ITEMS_PER_PHASE);
    drain_results();

    send_idle = 0;
    recv_idle = 0;
    send_random(ITEMS_PER_PHASE);
    drain_results();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("service_queue_with_undo_history test passed");
    end else begin
      $display("service_queue_with_undo_history test failed");
    end
    $finish;
  end

endmodule
